[sv/utf8d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] REPL_CHAR    = 21'h00FFFD;
   localparam logic [CP_W-1:0] MIN_TWO      = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE    = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR     = 21'h010000;
   localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
   localparam logic [CP_W-1:0] MAX_SCALAR   = 21'h10FFFF;

   localparam logic [1:0] CONT_TAG   = 2'b10;
   localparam logic [2:0] LEAD2_TAG  = 3'b110;
   localparam logic [3:0] LEAD3_TAG  = 4'b1110;
   localparam logic [4:0] LEAD4_TAG  = 5'b11110;

   localparam logic [1:0] LEN_NONE  = 2'd0;
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   typedef struct packed {
      logic [CP_W-1:0] partial_value;
      logic [1:0]      bytes_still_needed;
      logic [1:0]      sequence_length;
      logic            seen_bad_byte;
   } state_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            out_last;
   } result_type;

endpackage

[sv/utf8d_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_step
// Next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
module utf8d_step (
   input  utf8d_pkg::state_type  state_cur,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output utf8d_pkg::state_type  state_nxt,
   output logic                  res_valid,
   output utf8d_pkg::result_type res
);
   import utf8d_pkg::*;

   logic            is_idle;
   logic            is_ascii;
   logic            is_lead2;
   logic            is_lead3;
   logic            is_lead4;
   logic            not_cont;
   logic            bad_acc;
   logic [CP_W-1:0] shifted;
   logic [1:0]      need_dec;
   logic            val_bad;
   state_type       idle_state;

   assign is_idle  = (state_cur.bytes_still_needed == LEN_NONE);
   assign is_ascii = ~in_byte[7];
   assign is_lead2 = (in_byte[7:5] == LEAD2_TAG);
   assign is_lead3 = (in_byte[7:4] == LEAD3_TAG);
   assign is_lead4 = (in_byte[7:3] == LEAD4_TAG);
   assign not_cont = (in_byte[7:6] != CONT_TAG);
   assign bad_acc  = state_cur.seen_bad_byte | not_cont;
   assign shifted  = {state_cur.partial_value[CP_W-7:0], in_byte[5:0]};
   assign need_dec = state_cur.bytes_still_needed - 2'd1;

   assign idle_state = '{partial_value: '0, bytes_still_needed: LEN_NONE,
                         sequence_length: LEN_NONE, seen_bad_byte: 1'b0};

   // range check on the completed value, by sequence length
   always_comb begin
      case (state_cur.sequence_length)
         LEN_ONE:   val_bad = (shifted < MIN_TWO);
         LEN_TWO:   val_bad = (shifted < MIN_THREE) ||
                              ((shifted >= SURR_LO) && (shifted <= SURR_HI));
         LEN_THREE: val_bad = (shifted < MIN_FOUR) || (shifted > MAX_SCALAR);
         default:   val_bad = 1'b1;
      endcase
   end

   always_comb begin
      state_nxt      = idle_state;
      res_valid      = 1'b0;
      res.code_point = REPL_CHAR;
      res.replaced   = 1'b1;
      res.out_last   = in_last;
      if (is_idle) begin
         if (is_ascii) begin
            res_valid      = 1'b1;
            res.code_point = {{(CP_W-8){1'b0}}, in_byte};
            res.replaced   = 1'b0;
         end else if (is_lead2 || is_lead3 || is_lead4) begin
            if (in_last) begin
               res_valid = 1'b1;
            end else begin
               state_nxt.seen_bad_byte = 1'b0;
               if (is_lead2) begin
                  state_nxt.partial_value      = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                  state_nxt.bytes_still_needed = LEN_ONE;
                  state_nxt.sequence_length    = LEN_ONE;
               end else if (is_lead3) begin
                  state_nxt.partial_value      = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                  state_nxt.bytes_still_needed = LEN_TWO;
                  state_nxt.sequence_length    = LEN_TWO;
               end else begin
                  state_nxt.partial_value      = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                  state_nxt.bytes_still_needed = LEN_THREE;
                  state_nxt.sequence_length    = LEN_THREE;
               end
            end
         end else begin
            // stray continuation or F8-FF
            res_valid = 1'b1;
         end
      end else if (need_dec != LEN_NONE) begin
         if (in_last) begin
            // truncated sequence: one replacement, partial dropped
            res_valid = 1'b1;
         end else begin
            state_nxt.partial_value      = shifted;
            state_nxt.bytes_still_needed = need_dec;
            state_nxt.sequence_length    = state_cur.sequence_length;
            state_nxt.seen_bad_byte      = bad_acc;
         end
      end else begin
         res_valid = 1'b1;
         if (!(bad_acc || val_bad)) begin
            res.code_point = shifted;
            res.replaced   = 1'b0;
         end
      end
   end

endmodule

[sv/utf8d_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_out_buf
// Result register with a skid stage; decouples the input ready from the
// downstream ready.
// ----------------------------------------------------------------------------
module utf8d_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utf8d_pkg::result_type push_data,
   output logic                  can_push,
   output logic                  out_valid,
   input  logic                  out_ready,
   output utf8d_pkg::result_type out_data
);
   import utf8d_pkg::*;

   logic       main_valid_ff;
   logic       main_valid_in;
   result_type main_data_ff;
   result_type main_data_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_data_ff;
   result_type skid_data_in;

   assign can_push  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || out_ready) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (out_ready) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

[sv/utf8_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to code point decoder, one byte per word.
// ----------------------------------------------------------------------------
// Results are registered (result register, or skid stage while rsp_ stalls).
// Throughput: one byte per cycle while req_ready is high; the decode step is
//   a single pass from the sequence state registers to the result register.
// req_ready drops only when the result register and its skid stage are full.
// Reset: synchronous; returns to idle with both result stages empty.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_in_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [utf8d_pkg::CP_W-1:0]   rsp_code_point,
   output logic                         rsp_replaced,
   output logic                         rsp_out_last
);
   import utf8d_pkg::*;

   state_type  seq_ff;
   state_type  seq_in;
   state_type  step_state;
   logic       step_valid;
   result_type step_res;
   logic       accept;
   result_type out_res;

   assign accept = req_valid & req_ready;

   utf8d_step u_step (
      .state_cur (seq_ff),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .state_nxt (step_state),
      .res_valid (step_valid),
      .res       (step_res)
   );

   assign seq_in = accept ? step_state : seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else begin
         seq_ff <= seq_in;
      end
   end

   utf8d_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept & step_valid),
      .push_data (step_res),
      .can_push  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_res)
   );

   assign rsp_code_point = out_res.code_point;
   assign rsp_replaced   = out_res.replaced;
   assign rsp_out_last   = out_res.out_last;

endmodule
